// ----- rtl/core/c8_pkg.sv -----
// Package for the CHIP-8 instruction core: sizes, opcode codes, state and
// command/status types, hex font table.
// No dependencies.
`timescale 1ns / 1ps
package c8_pkg;

    localparam int MEM_AW       = 12;
    localparam int MEM_BYTES    = 1 << MEM_AW;
    localparam int PC_W         = 12;
    localparam int SCR_W        = 64;
    localparam int SCR_H        = 32;
    localparam int SCR_AW       = 5;
    localparam int STK_DEPTH    = 16;
    localparam int STK_AW       = 4;
    localparam int FONT_BASE    = 0;
    localparam int FONT_LEN     = 80;
    localparam int PROGRAM_BASE = 512;

    localparam logic [15:0] OPC_CLS   = 16'h00E0;
    localparam logic [15:0] OPC_RET   = 16'h00EE;
    localparam logic [7:0]  NN_SKP    = 8'h9E;
    localparam logic [7:0]  NN_SKNP   = 8'hA1;
    localparam logic [7:0]  NN_GETDT  = 8'h07;
    localparam logic [7:0]  NN_WAITK  = 8'h0A;
    localparam logic [7:0]  NN_SETDT  = 8'h15;
    localparam logic [7:0]  NN_SETST  = 8'h18;
    localparam logic [7:0]  NN_ADDI   = 8'h1E;
    localparam logic [7:0]  NN_FONT   = 8'h29;
    localparam logic [7:0]  NN_BCD    = 8'h33;
    localparam logic [7:0]  NN_STORE  = 8'h55;
    localparam logic [7:0]  NN_LOAD   = 8'h65;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_MEMWR = 2'd1,
        OP_MEMRD = 2'd2,
        OP_ROWRD = 2'd3
    } t_oper;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_UNDEF = 2'd1,
        FLT_OVER  = 2'd2,
        FLT_UNDER = 2'd3
    } t_fault;

    typedef enum logic [1:0] {
        RA_PC, RA_PC1, RA_ADDR, RA_IDX
    } t_rsel;

    typedef enum logic [2:0] {
        WA_NONE, WA_CLR, WA_HOST, WA_BCD, WA_DUMP
    } t_wsel;

    typedef enum logic [2:0] {
        MC_NONE, MC_DRAW, MC_BCD, MC_STORE, MC_LOAD
    } t_mclass;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_HWR, S_HRD, S_F0, S_F1, S_F2, S_RX, S_RY,
        S_EX, S_BCD, S_ST, S_LD0, S_LD1, S_DR0, S_DR1, S_DFIN, S_TIM, S_OUT
    } t_state;

    typedef struct packed {
        logic  accept;
        t_rsel rsel;
        t_wsel wsel;
        logic  clr_inc;
        logic  ld_op_hi;
        logic  ld_op_lo;
        logic  ld_vx;
        logic  ld_vy;
        logic  exec;
        logic  draw_row;
        logic  load_row;
        logic  fin_draw;
        logic  cnt_clr;
        logic  cnt_inc;
        logic  tick;
        logic  out_ld;
    } t_cmd;

    typedef struct packed {
        t_oper   opn;
        t_mclass mclass;
        logic    draw_empty;
        logic    cnt_last;
        logic    clr_last;
    } t_stat;

    function automatic logic [7:0] glyph(input logic [6:0] k);
        logic [7:0] g;
        case (k)
            7'd0,  7'd4,  7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25,
            7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45,
            7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75,
            7'd77: g = 8'hF0;
            7'd1,  7'd2,  7'd3,  7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51,
            7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: g = 8'h90;
            7'd5,  7'd7,  7'd8,  7'd37: g = 8'h20;
            7'd6:  g = 8'h60;
            7'd9:  g = 8'h70;
            7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: g = 8'h10;
            7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
            7'd79: g = 8'h80;
            7'd38, 7'd39: g = 8'h40;
            7'd55, 7'd57, 7'd59, 7'd65, 7'd69: g = 8'hE0;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/core/chip8_instruction_core.sv -----
// Host write/read: dispatch, access, output state, then o_done; row read:
// dispatch, output; step: fetch, VX/VY read, execute, timer tick, output, plus
// byte states for FX33/FX55/FX65 and row states for DXYN (one main memory port).
// One item at a time; busy stays high until the result strobe has been issued.
// After reset a pass over all 4096 memory bytes loads the font and clears memory, busy high.
// Results are strobed for one cycle on o_done; the receiver cannot stall.
`timescale 1ns / 1ps
module chip8_instruction_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_operation,
    input  logic [c8_pkg::MEM_AW-1:0] i_address,
    input  logic [7:0]                i_write_data,
    input  logic [15:0]               i_keys_down,
    input  logic [7:0]                i_random_byte,
    output logic [7:0]                o_read_data,
    output logic [c8_pkg::SCR_W-1:0]  o_screen_row,
    output logic [c8_pkg::PC_W-1:0]   o_program_counter,
    output logic                      o_sound_on,
    output logic                      o_screen_changed,
    output logic [1:0]                o_fault_code,
    output logic                      o_done
);
    import c8_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    c8_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    c8_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_operation       (i_operation),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_keys_down       (i_keys_down),
        .i_random_byte     (i_random_byte),
        .o_read_data       (o_read_data),
        .o_screen_row      (o_screen_row),
        .o_program_counter (o_program_counter),
        .o_sound_on        (o_sound_on),
        .o_screen_changed  (o_screen_changed),
        .o_fault_code      (o_fault_code),
        .o_done            (o_done)
    );

endmodule

// ----- rtl/core/c8_ctrl.sv -----
// Sequencer for the CHIP-8 core: memory clear pass, host operations and
// the fetch/decode/execute phases of a step. Uses c8_pkg.
`timescale 1ns / 1ps
module c8_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  c8_pkg::t_stat i_stat,
    output c8_pkg::t_cmd  o_cmd
);
    import c8_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rsel = RA_PC;
        o_cmd.wsel = WA_NONE;
        case (r_state)
            S_CLR: begin
                o_cmd.wsel    = WA_CLR;
                o_cmd.clr_inc = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.opn)
                    OP_STEP:  n_state = S_F0;
                    OP_MEMWR: n_state = S_HWR;
                    OP_MEMRD: n_state = S_HRD;
                    default:  n_state = S_OUT;
                endcase
            end
            S_HWR: begin
                o_cmd.wsel = WA_HOST;
                n_state    = S_OUT;
            end
            S_HRD: begin
                o_cmd.rsel = RA_ADDR;
                n_state    = S_OUT;
            end
            S_F0: begin
                o_cmd.rsel = RA_PC;
                n_state    = S_F1;
            end
            S_F1: begin
                o_cmd.rsel     = RA_PC1;
                o_cmd.ld_op_hi = 1'b1;
                n_state        = S_F2;
            end
            S_F2: begin
                o_cmd.ld_op_lo = 1'b1;
                n_state        = S_RX;
            end
            S_RX: begin
                o_cmd.ld_vx = 1'b1;
                n_state     = S_RY;
            end
            S_RY: begin
                o_cmd.ld_vy = 1'b1;
                n_state     = S_EX;
            end
            S_EX: begin
                o_cmd.exec    = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                case (i_stat.mclass)
                    MC_DRAW:  n_state = i_stat.draw_empty ? S_DFIN : S_DR0;
                    MC_BCD:   n_state = S_BCD;
                    MC_STORE: n_state = S_ST;
                    MC_LOAD:  n_state = S_LD0;
                    default:  n_state = S_TIM;
                endcase
            end
            S_BCD: begin
                o_cmd.wsel    = WA_BCD;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt_last) n_state = S_TIM;
            end
            S_ST: begin
                o_cmd.wsel    = WA_DUMP;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt_last) n_state = S_TIM;
            end
            S_LD0: begin
                o_cmd.rsel = RA_IDX;
                n_state    = S_LD1;
            end
            S_LD1: begin
                o_cmd.load_row = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                n_state        = i_stat.cnt_last ? S_TIM : S_LD0;
            end
            S_DR0: begin
                o_cmd.rsel = RA_IDX;
                n_state    = S_DR1;
            end
            S_DR1: begin
                o_cmd.draw_row = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                n_state        = i_stat.cnt_last ? S_DFIN : S_DR0;
            end
            S_DFIN: begin
                o_cmd.fin_draw = 1'b1;
                n_state        = S_TIM;
            end
            S_TIM: begin
                o_cmd.tick = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_ld = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/c8_dp.sv -----
// Datapath for the CHIP-8 core: main memory, registers, call stack,
// timers, frame store and result registers. Uses c8_pkg.
`timescale 1ns / 1ps
module c8_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  c8_pkg::t_cmd              i_cmd,
    output c8_pkg::t_stat             o_stat,
    input  logic [1:0]                i_operation,
    input  logic [c8_pkg::MEM_AW-1:0] i_address,
    input  logic [7:0]                i_write_data,
    input  logic [15:0]               i_keys_down,
    input  logic [7:0]                i_random_byte,
    output logic [7:0]                o_read_data,
    output logic [c8_pkg::SCR_W-1:0]  o_screen_row,
    output logic [c8_pkg::PC_W-1:0]   o_program_counter,
    output logic                      o_sound_on,
    output logic                      o_screen_changed,
    output logic [1:0]                o_fault_code,
    output logic                      o_done
);
    import c8_pkg::*;

    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_mrd;
    logic [7:0]        r_v [16];
    logic [PC_W-1:0]   r_stk [STK_DEPTH];
    logic [SCR_W-1:0]  r_frame [SCR_H];
    logic [15:0]       r_i, n_i;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [STK_AW:0]   r_sp, n_sp;
    logic [7:0]        r_dt, n_dt, r_st, n_st;
    logic [15:0]       r_op;
    logic [7:0]        r_vx, r_vy;
    logic [3:0]        r_cnt, n_cnt;
    logic              r_hit, n_hit, r_chg, n_chg;
    t_fault            r_fault, n_fault;
    logic [MEM_AW-1:0] r_clr;
    t_oper             r_opn;
    logic [MEM_AW-1:0] r_addr;
    logic [7:0]        r_wdata, r_rnd;
    logic [15:0]       r_keys;

    logic [3:0]        x, y, lo, hi, rf_idx, va_idx;
    logic [7:0]        nn, rf_rd, va_d, vf_d;
    logic [11:0]       nnn;
    logic              va_we, vf_we, stk_we, fr_clr, fr_we;
    logic [STK_AW-1:0] stk_top;
    logic [MEM_AW-1:0] ra, wa, ia, font_off;
    logic [7:0]        wd;
    logic              we;
    logic [8:0]        sum9, drow;
    logic              row_ok;
    logic [SCR_AW-1:0] fidx;
    logic [SCR_W-1:0]  fr_rd, mask;
    logic [1:0]        bcd_h;
    logic [7:0]        bcd_rem;
    logic [14:0]       bcd_prod;
    logic [3:0]        bcd_t;
    logic [7:0]        bcd_u, bcd_d;
    logic              key;

    assign hi  = r_op[15:12];
    assign x   = r_op[11:8];
    assign y   = r_op[7:4];
    assign lo  = r_op[3:0];
    assign nn  = r_op[7:0];
    assign nnn = r_op[11:0];

    // status
    always_comb begin
        o_stat.opn        = r_opn;
        o_stat.mclass     = MC_NONE;
        o_stat.draw_empty = (lo == 4'd0);
        o_stat.clr_last   = (r_clr == MEM_AW'(MEM_BYTES - 1));
        if (hi == 4'hD) begin
            o_stat.mclass = MC_DRAW;
        end else if (hi == 4'hF) begin
            case (nn)
                NN_BCD:   o_stat.mclass = MC_BCD;
                NN_STORE: o_stat.mclass = MC_STORE;
                NN_LOAD:  o_stat.mclass = MC_LOAD;
                default:  o_stat.mclass = MC_NONE;
            endcase
        end
        case (o_stat.mclass)
            MC_DRAW:            o_stat.cnt_last = (r_cnt == lo - 4'd1);
            MC_BCD:             o_stat.cnt_last = (r_cnt == 4'd2);
            MC_STORE, MC_LOAD:  o_stat.cnt_last = (r_cnt == x);
            default:            o_stat.cnt_last = 1'b1;
        endcase
    end

    // BCD digits
    always_comb begin
        if (r_vx >= 8'd200)      bcd_h = 2'd2;
        else if (r_vx >= 8'd100) bcd_h = 2'd1;
        else                     bcd_h = 2'd0;
        bcd_rem  = r_vx - ({6'd0, bcd_h} * 8'd100);
        bcd_prod = {8'd0, bcd_rem[6:0]} * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_u    = bcd_rem - ({4'd0, bcd_t} * 8'd10);
        case (r_cnt[1:0])
            2'd0:    bcd_d = {6'd0, bcd_h};
            2'd1:    bcd_d = {4'd0, bcd_t};
            default: bcd_d = bcd_u;
        endcase
    end

    // memory ports
    assign ia       = r_i[MEM_AW-1:0] + MEM_AW'(r_cnt);
    assign font_off = r_clr - MEM_AW'(FONT_BASE);
    assign rf_idx   = (i_cmd.wsel == WA_DUMP) ? r_cnt :
                      i_cmd.ld_vy ? y : ((hi == 4'hB) ? 4'd0 : x);
    assign rf_rd    = r_v[rf_idx];

    always_comb begin
        case (i_cmd.rsel)
            RA_PC:   ra = r_pc;
            RA_PC1:  ra = r_pc + 12'd1;
            RA_ADDR: ra = r_addr;
            default: ra = ia;
        endcase
        we = 1'b1;
        wa = ia;
        wd = rf_rd;
        case (i_cmd.wsel)
            WA_CLR: begin
                wa = r_clr;
                wd = (font_off < MEM_AW'(FONT_LEN)) ? glyph(font_off[6:0]) : 8'd0;
            end
            WA_HOST: begin
                wa = r_addr;
                wd = r_wdata;
            end
            WA_BCD:  wd = bcd_d;
            WA_DUMP: wd = rf_rd;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_mrd <= r_mem[ra];
    end

    // sprite row
    assign drow   = {1'b0, r_vy} + {5'd0, r_cnt};
    assign fidx   = i_cmd.draw_row ? drow[SCR_AW-1:0] : r_addr[SCR_AW-1:0];
    assign fr_rd  = r_frame[fidx];
    assign mask   = {r_mrd, (SCR_W - 8)'(0)} >> r_vx;
    assign row_ok = (r_addr < MEM_AW'(SCR_H));
    assign stk_top = r_sp[STK_AW-1:0] - 1'b1;
    assign sum9   = {1'b0, r_vx} + {1'b0, r_vy};
    assign key    = r_keys[r_vx[3:0]];

    always_comb begin
        n_pc = r_pc; n_i = r_i; n_sp = r_sp; n_dt = r_dt; n_st = r_st;
        n_fault = r_fault; n_chg = r_chg; n_hit = r_hit; n_cnt = r_cnt;
        va_we = 1'b0; va_idx = x; va_d = 8'd0; vf_we = 1'b0; vf_d = 8'd0;
        stk_we = 1'b0; fr_clr = 1'b0; fr_we = 1'b0;
        if (i_cmd.accept) begin
            n_fault = FLT_NONE;
            n_chg   = 1'b0;
        end
        if (i_cmd.ld_op_lo) n_pc = r_pc + 12'd2;
        if (i_cmd.exec) begin
            case (hi)
                4'h0: begin
                    if (r_op == OPC_CLS) begin
                        fr_clr = 1'b1;
                        n_chg  = 1'b1;
                    end else if (r_op == OPC_RET) begin
                        if (r_sp == '0) begin
                            n_fault = FLT_UNDER;
                        end else begin
                            n_sp = r_sp - 1'b1;
                            n_pc = r_stk[stk_top];
                        end
                    end
                end
                4'h1: n_pc = nnn;
                4'h2: begin
                    if (r_sp >= (STK_AW + 1)'(STK_DEPTH)) begin
                        n_fault = FLT_OVER;
                    end else begin
                        stk_we = 1'b1;
                        n_sp   = r_sp + 1'b1;
                        n_pc   = nnn;
                    end
                end
                4'h3: if (r_vx == nn) n_pc = r_pc + 12'd2;
                4'h4: if (r_vx != nn) n_pc = r_pc + 12'd2;
                4'h5, 4'h9: begin
                    if (lo != 4'd0)
                        n_fault = FLT_UNDEF;
                    else if ((r_vx == r_vy) == (hi == 4'h5))
                        n_pc = r_pc + 12'd2;
                end
                4'h6: begin va_we = 1'b1; va_d = nn; end
                4'h7: begin va_we = 1'b1; va_d = r_vx + nn; end
                4'h8: begin
                    va_we = 1'b1;
                    case (lo)
                        4'h0: va_d = r_vy;
                        4'h1: va_d = r_vx | r_vy;
                        4'h2: va_d = r_vx & r_vy;
                        4'h3: va_d = r_vx ^ r_vy;
                        4'h4: begin
                            va_d = sum9[7:0]; vf_we = 1'b1; vf_d = {7'd0, sum9[8]};
                        end
                        4'h5: begin
                            va_d = r_vx - r_vy; vf_we = 1'b1; vf_d = {7'd0, r_vx >= r_vy};
                        end
                        4'h6: begin
                            va_d = {1'b0, r_vx[7:1]}; vf_we = 1'b1; vf_d = {7'd0, r_vx[0]};
                        end
                        4'h7: begin
                            va_d = r_vy - r_vx; vf_we = 1'b1; vf_d = {7'd0, r_vy >= r_vx};
                        end
                        4'hE: begin
                            va_d = {r_vx[6:0], 1'b0}; vf_we = 1'b1; vf_d = {7'd0, r_vx[7]};
                        end
                        default: begin
                            va_we   = 1'b0;
                            n_fault = FLT_UNDEF;
                        end
                    endcase
                end
                4'hA: n_i = {4'd0, nnn};
                4'hB: n_pc = nnn + {4'd0, r_vx};
                4'hC: begin va_we = 1'b1; va_d = r_rnd & nn; end
                4'hD: begin n_chg = 1'b1; n_hit = 1'b0; end
                4'hE: begin
                    if (nn == NN_SKP) begin
                        if (key) n_pc = r_pc + 12'd2;
                    end else if (nn == NN_SKNP) begin
                        if (!key) n_pc = r_pc + 12'd2;
                    end else begin
                        n_fault = FLT_UNDEF;
                    end
                end
                default: begin
                    case (nn)
                        NN_GETDT: begin va_we = 1'b1; va_d = r_dt; end
                        NN_WAITK, NN_BCD, NN_STORE, NN_LOAD: ;
                        NN_SETDT: n_dt = r_vx;
                        NN_SETST: n_st = r_vx;
                        NN_ADDI:  n_i = r_i + {8'd0, r_vx};
                        NN_FONT:  n_i = 16'(FONT_BASE) + {10'd0, r_vx[3:0], 2'd0}
                                        + {12'd0, r_vx[3:0]};
                        default:  n_fault = FLT_UNDEF;
                    endcase
                end
            endcase
        end
        if (i_cmd.draw_row && drow < 9'(SCR_H)) begin
            fr_we = 1'b1;
            n_hit = r_hit | (|(fr_rd & mask));
        end
        if (i_cmd.load_row) begin
            va_we  = 1'b1;
            va_idx = r_cnt;
            va_d   = r_mrd;
        end
        if (i_cmd.fin_draw) begin
            vf_we = 1'b1;
            vf_d  = {7'd0, r_hit};
        end
        // flag write wins over VX when X is F
        if (vf_we && va_idx == 4'hF) va_we = 1'b0;
        if (i_cmd.cnt_clr) n_cnt = 4'd0;
        if (i_cmd.cnt_inc) n_cnt = r_cnt + 4'd1;
        if (i_cmd.tick) begin
            if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
            if (r_st != 8'd0) n_st = r_st - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_W'(PROGRAM_BASE);
            r_i     <= '0;
            r_sp    <= '0;
            r_dt    <= '0;
            r_st    <= '0;
            r_fault <= FLT_NONE;
            r_chg   <= 1'b0;
            r_hit   <= 1'b0;
            r_cnt   <= '0;
            r_clr   <= '0;
            r_opn   <= OP_STEP;
            o_done  <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            for (int k = 0; k < STK_DEPTH; k++) r_stk[k] <= '0;
            for (int k = 0; k < SCR_H; k++) r_frame[k] <= '0;
        end else begin
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_sp    <= n_sp;
            r_dt    <= n_dt;
            r_st    <= n_st;
            r_fault <= n_fault;
            r_chg   <= n_chg;
            r_hit   <= n_hit;
            r_cnt   <= n_cnt;
            o_done  <= i_cmd.out_ld;
            if (i_cmd.clr_inc) r_clr <= r_clr + 1'b1;
            if (i_cmd.accept) r_opn <= t_oper'(i_operation);
            if (va_we) r_v[va_idx] <= va_d;
            if (vf_we) r_v[15] <= vf_d;
            if (stk_we) r_stk[r_sp[STK_AW-1:0]] <= r_pc;
            if (fr_clr) begin
                for (int k = 0; k < SCR_H; k++) r_frame[k] <= '0;
            end else if (fr_we) begin
                r_frame[fidx] <= fr_rd ^ mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_keys  <= i_keys_down;
            r_rnd   <= i_random_byte;
        end
        if (i_cmd.ld_op_hi) r_op[15:8] <= r_mrd;
        if (i_cmd.ld_op_lo) r_op[7:0] <= r_mrd;
        if (i_cmd.ld_vx) r_vx <= rf_rd;
        if (i_cmd.ld_vy) r_vy <= rf_rd;
        if (i_cmd.out_ld) begin
            o_read_data       <= (r_opn == OP_MEMRD) ? r_mrd : 8'd0;
            o_screen_row      <= (r_opn == OP_ROWRD && row_ok) ? fr_rd : '0;
            o_program_counter <= r_pc;
            o_sound_on        <= (r_st != 8'd0);
            o_screen_changed  <= r_chg;
            o_fault_code      <= r_fault;
        end
    end

endmodule

// ----- verif/chip8_instruction_core_tb.sv -----
// Self-checking testbench for chip8_instruction_core: loads programs, single-steps
// them and reads memory and screen rows back, checking every result against an
// in-bench CHIP-8 interpreter. Depends on c8_pkg and the core RTL.
`timescale 1ns / 1ps
module chip8_instruction_core_tb;
    import c8_pkg::*;

    typedef struct {
        t_oper       op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [15:0] keys;
        logic [7:0]  rnd;
    } t_item;

    typedef struct {
        logic [7:0]  rd;
        logic [63:0] row;
        logic [11:0] pc;
        logic        snd;
        logic        chg;
        t_fault      flt;
    } t_res;

    localparam logic [7:0] FONT_ROM [0:79] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = '0;
    logic [11:0] i_address = '0;
    logic [7:0]  i_write_data = '0;
    logic [15:0] i_keys_down = '0;
    logic [7:0]  i_random_byte = '0;
    logic [7:0]  o_read_data;
    logic [63:0] o_screen_row;
    logic [11:0] o_program_counter;
    logic        o_sound_on;
    logic        o_screen_changed;
    logic [1:0]  o_fault_code;
    logic        o_done;

    chip8_instruction_core uut (.*);

    always #4 i_clk = ~i_clk;

    // interpreter state
    logic [7:0]  mem [0:4095];
    logic [7:0]  vreg [0:15];
    logic [15:0] idx;
    logic [11:0] cpu_pc;
    logic [11:0] stk [0:15];
    int          sp;
    logic [7:0]  delay_cnt, sound_cnt;
    logic [63:0] frame [0:31];

    t_item pending[$];
    t_res  expected[$];
    logic  taken = 1'b0;
    logic  calm = 1'b0;
    int    errors = 0;
    int    issued = 0;

    task automatic draw_sprite(input logic [3:0] x, input logic [3:0] y, input logic [3:0] n);
        logic [15:0] a;
        logic [7:0]  bits;
        int          row, col;
        logic        hit;
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
            a = idx + 16'(r);
            bits = mem[a[11:0]];
            row = vreg[y] + r;
            if (row >= 32) continue;
            for (int c = 0; c < 8; c++) begin
                col = vreg[x] + c;
                if (!bits[7-c] || col >= 64) continue;
                if (frame[row][63-col]) hit = 1'b1;
                frame[row][63-col] = ~frame[row][63-col];
            end
        end
        vreg[15] = {7'd0, hit};
    endtask

    task automatic exec_insn(input logic [15:0] keys, input logic [7:0] rnd,
                             output t_fault flt, output logic chg);
        logic [15:0] op;
        logic [3:0]  x, y, lo;
        logic [7:0]  nn, vx, vy;
        logic [11:0] nnn;
        logic [8:0]  sum;
        logic [15:0] a;
        op = {mem[cpu_pc], mem[cpu_pc + 12'd1]};
        x = op[11:8]; y = op[7:4]; lo = op[3:0]; nn = op[7:0]; nnn = op[11:0];
        vx = vreg[x]; vy = vreg[y];
        flt = FLT_NONE; chg = 1'b0;
        cpu_pc = cpu_pc + 12'd2;
        case (op[15:12])
            4'h0: begin
                if (op == OPC_CLS) begin
                    foreach (frame[r]) frame[r] = '0;
                    chg = 1'b1;
                end else if (op == OPC_RET) begin
                    if (sp == 0) flt = FLT_UNDER;
                    else begin
                        sp--;
                        cpu_pc = stk[sp];
                    end
                end
            end
            4'h1: cpu_pc = nnn;
            4'h2: begin
                if (sp >= 16) flt = FLT_OVER;
                else begin
                    stk[sp] = cpu_pc;
                    sp++;
                    cpu_pc = nnn;
                end
            end
            4'h3: if (vx == nn) cpu_pc = cpu_pc + 12'd2;
            4'h4: if (vx != nn) cpu_pc = cpu_pc + 12'd2;
            4'h5: if (lo != 0) flt = FLT_UNDEF; else if (vx == vy) cpu_pc = cpu_pc + 12'd2;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vx + nn;
            4'h8: begin
                case (lo)
                    4'h0: vreg[x] = vy;
                    4'h1: vreg[x] = vx | vy;
                    4'h2: vreg[x] = vx & vy;
                    4'h3: vreg[x] = vx ^ vy;
                    4'h4: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                    end
                    4'h5: begin vreg[x] = vx - vy; vreg[15] = {7'd0, vx >= vy}; end
                    4'h6: begin vreg[x] = vx >> 1; vreg[15] = {7'd0, vx[0]}; end
                    4'h7: begin vreg[x] = vy - vx; vreg[15] = {7'd0, vy >= vx}; end
                    4'hE: begin vreg[x] = vx << 1; vreg[15] = {7'd0, vx[7]}; end
                    default: flt = FLT_UNDEF;
                endcase
            end
            4'h9: if (lo != 0) flt = FLT_UNDEF; else if (vx != vy) cpu_pc = cpu_pc + 12'd2;
            4'hA: idx = {4'd0, nnn};
            4'hB: cpu_pc = {4'd0, vreg[0]} + nnn;
            4'hC: vreg[x] = rnd & nn;
            4'hD: begin draw_sprite(x, y, lo); chg = 1'b1; end
            4'hE: begin
                if (nn == NN_SKP) begin
                    if (keys[vx[3:0]]) cpu_pc = cpu_pc + 12'd2;
                end else if (nn == NN_SKNP) begin
                    if (!keys[vx[3:0]]) cpu_pc = cpu_pc + 12'd2;
                end else flt = FLT_UNDEF;
            end
            default: begin
                case (nn)
                    NN_GETDT: vreg[x] = delay_cnt;
                    NN_WAITK: ;
                    NN_SETDT: delay_cnt = vx;
                    NN_SETST: sound_cnt = vx;
                    NN_ADDI:  idx = idx + {8'd0, vx};
                    NN_FONT:  idx = 16'(FONT_BASE) + 16'd5 * vx[3:0];
                    NN_BCD: begin
                        mem[idx[11:0]] = vx / 100;
                        a = idx + 16'd1; mem[a[11:0]] = (vx % 100) / 10;
                        a = idx + 16'd2; mem[a[11:0]] = vx % 10;
                    end
                    NN_STORE: for (int i = 0; i <= x; i++) begin
                        a = idx + 16'(i); mem[a[11:0]] = vreg[i];
                    end
                    NN_LOAD: for (int i = 0; i <= x; i++) begin
                        a = idx + 16'(i); vreg[i] = mem[a[11:0]];
                    end
                    default: flt = FLT_UNDEF;
                endcase
            end
        endcase
    endtask

    task automatic predict_result(input t_item it, output t_res r);
        r.rd = '0; r.row = '0; r.chg = 1'b0; r.flt = FLT_NONE;
        case (it.op)
            OP_STEP: begin
                exec_insn(it.keys, it.rnd, r.flt, r.chg);
                if (delay_cnt != 0) delay_cnt--;
                if (sound_cnt != 0) sound_cnt--;
            end
            OP_MEMWR: mem[it.addr] = it.data;
            OP_MEMRD: r.rd = mem[it.addr];
            default:  if (it.addr < 32) r.row = frame[it.addr];
        endcase
        r.pc = cpu_pc;
        r.snd = sound_cnt != 0;
    endtask

    // driver
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n && (!start || taken)) begin
            if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
                it = pending.pop_front();
                start <= 1'b1;
                i_operation <= it.op;
                i_address <= it.addr;
                i_write_data <= it.data;
                i_keys_down <= it.keys;
                i_random_byte <= it.rnd;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and prediction; result check before new prediction on a shared edge
    always @(posedge i_clk) begin
        t_item it;
        t_res  r, e;
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_done) begin
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = expected.pop_front();
                if (o_read_data !== e.rd || o_screen_row !== e.row ||
                    o_program_counter !== e.pc || o_sound_on !== e.snd ||
                    o_screen_changed !== e.chg || o_fault_code !== e.flt) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at %0t: exp rd=%h row=%h pc=%h snd=%b chg=%b flt=%0d",
                                 $realtime, e.rd, e.row, e.pc, e.snd, e.chg, e.flt,
                                 "\n  got rd=%h row=%h pc=%h snd=%b chg=%b flt=%0d",
                                 o_read_data, o_screen_row, o_program_counter,
                                 o_sound_on, o_screen_changed, o_fault_code);
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            it.op = t_oper'(i_operation); it.addr = i_address; it.data = i_write_data;
            it.keys = i_keys_down; it.rnd = i_random_byte;
            predict_result(it, r);
            expected.push_back(r);
        end
    end

    task automatic put(input t_oper op, input logic [11:0] addr, input logic [7:0] data);
        t_item it;
        it.op = op; it.addr = addr; it.data = data;
        it.keys = 16'($urandom); it.rnd = 8'($urandom);
        pending.push_back(it);
        issued++;
    endtask

    task automatic put_word(input logic [11:0] addr, input logic [15:0] w);
        put(OP_MEMWR, addr, w[15:8]);
        put(OP_MEMWR, addr + 12'd1, w[7:0]);
    endtask

    function automatic logic [15:0] rand_insn();
        logic [15:0] w;
        logic [7:0]  fsel [0:8];
        fsel = '{NN_GETDT, NN_WAITK, NN_SETDT, NN_SETST, NN_ADDI, NN_FONT,
                 NN_BCD, NN_STORE, NN_LOAD};
        w = 16'($urandom);
        case (w[15:12])
            4'h0: case ($urandom_range(0, 3))
                0, 1: w = OPC_CLS + ($urandom_range(0, 3) == 0 ? 16'd0 : 16'h000E);
                2: w = OPC_RET;
                default: ;
            endcase
            4'h1, 4'h2: if ($urandom_range(0, 3) != 0) w[11:0] = 12'h200 + 12'($urandom_range(0, 511));
            4'h5, 4'h9: if ($urandom_range(0, 7) != 0) w[3:0] = 4'h0;
            4'h8: if ($urandom_range(0, 7) != 0) w[3:0] = $urandom_range(0, 8) == 8 ? 4'hE
                                                          : 4'($urandom_range(0, 7));
            4'hD: if ($urandom_range(0, 3) != 0) w[3:0] = 4'($urandom_range(0, 5));
            4'hE: if ($urandom_range(0, 7) != 0) w[7:0] = w[0] ? NN_SKP : NN_SKNP;
            4'hF: if ($urandom_range(0, 7) != 0) w[7:0] = fsel[$urandom_range(0, 8)];
            default: ;
        endcase
        return w;
    endfunction

    localparam logic [15:0] DIR_PROG [0:18] = '{
        16'h60FF, 16'h6101, 16'h8014, 16'h8F0E, 16'h6C3C, 16'h6D1E, 16'hA000,
        16'hDCDF, 16'hA300, 16'h60FF, 16'hF033, 16'hFF55, 16'hFF65, 16'h5011,
        16'hF118, 16'hE09E, 16'hC0FF, 16'h00E0, 16'hFFFF
    };

    initial begin
        int n;
        logic [11:0] a;
        foreach (mem[k]) mem[k] = k < 80 ? FONT_ROM[k] : 8'h00;
        foreach (vreg[k]) vreg[k] = '0;
        foreach (stk[k]) stk[k] = '0;
        foreach (frame[k]) frame[k] = '0;
        idx = '0; cpu_pc = 12'(PROGRAM_BASE); sp = 0; delay_cnt = '0; sound_cnt = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // stack fill to overflow, then drain to underflow
        put_word(12'h200, 16'h2200);
        put_word(12'h202, OPC_RET);
        repeat (17) put(OP_STEP, 12'($urandom), 8'($urandom));
        repeat (17) put(OP_STEP, 12'($urandom), 8'($urandom));
        foreach (DIR_PROG[k]) put_word(12'h204 + 12'(2 * k), DIR_PROG[k]);
        foreach (DIR_PROG[k]) put(OP_STEP, 12'($urandom), 8'($urandom));
        put(OP_MEMWR, 12'hFFF, 8'hFF);
        put(OP_MEMRD, 12'hFFF, 8'h00);
        put(OP_MEMRD, 12'h300, 8'h00);
        put(OP_ROWRD, 12'd31, 8'h00);
        put(OP_ROWRD, 12'd30, 8'h00);
        put(OP_ROWRD, 12'd32, 8'h00);
        put(OP_ROWRD, 12'hFFF, 8'h00);

        while (issued < 850) begin
            wait (pending.size() == 0 && expected.size() == 0 && !start);
            @(negedge i_clk);
            calm = issued > 350 && issued < 500;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(3, 12)) begin
                    case ($urandom_range(0, 3))
                        0: put(OP_STEP, 12'($urandom), 8'($urandom));
                        1: put(OP_MEMWR, 12'($urandom), 8'($urandom));
                        2: put(OP_MEMRD, 12'($urandom), 8'($urandom));
                        default: put(OP_ROWRD, $urandom_range(0, 7) == 0 ? 12'($urandom)
                                     : 12'($urandom_range(0, 31)), 8'($urandom));
                    endcase
                end
            end else begin
                n = $urandom_range(1, 12);
                a = cpu_pc;
                for (int k = 0; k < n; k++) put_word(a + 12'(2 * k), rand_insn());
                repeat (n + $urandom_range(0, 3)) put(OP_STEP, 12'($urandom), 8'($urandom));
                if ($urandom_range(0, 1) == 0)
                    put(OP_ROWRD, 12'($urandom_range(0, 31)), 8'($urandom));
                if ($urandom_range(0, 3) == 0)
                    put(OP_MEMRD, 12'(idx) + 12'($urandom_range(0, 15)), 8'($urandom));
            end
        end

        wait (pending.size() == 0 && expected.size() == 0 && !start);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/c8_pkg.sv
rtl/core/c8_ctrl.sv
rtl/core/c8_dp.sv
rtl/core/chip8_instruction_core.sv
verif/chip8_instruction_core_tb.sv
